### hdl/height_to_normal_map_defines.svh
// Assertion helpers for the height_to_normal_map checker.
`ifndef HEIGHT_TO_NORMAL_MAP_DEFINES_SVH
`define HEIGHT_TO_NORMAL_MAP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define HNM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HNM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### hdl/hnm_pkg.sv
package hnm_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_EDGES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_GAIN = 2'd3;

	localparam logic [10:0] ROW_LENGTH_RST = 11'd1024;
	localparam logic [10:0] ROW_COUNT_RST  = 11'd1024;
	localparam logic [15:0] SLOPE_GAIN_RST = 16'd256;

	localparam logic [7:0] ALPHA_VAL = 8'hFF;

	// 65280^2, the unit term of the squared magnitude
	localparam logic [49:0] BASE_SQ = 50'd4261478400;
	// (65280*65536)^2 shifted right by 33; all lower numerator bits are zero
	localparam logic [49:0] DIV_SEED = 50'd2130739200;
	// 255*128, lifts the scaled component to a non-negative value
	localparam logic signed [49:0] LIFT = 50'sd32640;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_RD0,
		SEQ_RD1,
		SEQ_RD2,
		SEQ_RD3,
		SEQ_WR,
		SEQ_PICK,
		SEQ_CALC,
		SEQ_OUT
	} seq_state_t;

	typedef enum logic [3:0] {
		NRM_IDLE,
		NRM_DIFF,
		NRM_SQX,
		NRM_SQY,
		NRM_DIV,
		NRM_SQRT,
		NRM_MULX,
		NRM_MULY,
		NRM_SCALE,
		NRM_FIX,
		NRM_DONE
	} nrm_state_t;

	typedef struct packed {
		logic        start;
		logic [7:0]  hc;
		logic [7:0]  hl;
		logic [7:0]  hu;
		logic [15:0] gain;
	} nrm_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] nz;
	} nrm_rsp_t;

endpackage

### hdl/height_to_normal_map.sv
// Height map to normal map, one sample at a time from raster order.
// The sequencer reads both row stores, writes the sample, then picks each result it releases;
// each result passes through the shared normal unit (33-step divider and 17-step square root)
// and waits in SEQ_OUT until the output register is free. A new sample is taken only in idle,
// after every result of the last one has been loaded; results leave from a registered output.
// Reset clears counters, edge registers and the output valid flag; the row stores hold no reset.
module height_to_normal_map import hnm_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [15:0]          cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // height_sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_row, out_column, normal_x, normal_y, normal_z, normal_alpha, zero pad
	output logic [55:0]          m_tdata,
	output logic                 m_tlast
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [10:0] row_length_q, row_count_q;
	logic        wrap_q;
	logic [15:0] gain_q;

	logic [AW-1:0] w_m1, col_q, c_it_q;
	logic [RW-1:0] h_m1, row_q, r_it_q;
	logic [7:0] left_q, head_lo_q, head_hi_q;
	logic [7:0] cur_q, left_it_q, hlo_it_q, hhi_it_q;
	logic [7:0] up_q, fc_q, fc1_q, f0_q, fw_q;

	seq_state_t state_q, state_d;
	logic [3:0] done_q;
	logic [1:0] slot_q;
	logic       last_q;

	logic       o_valid_q, o_last_q;
	logic [9:0] o_row_q, o_col_q;
	logic [7:0] o_x_q, o_y_q, o_z_q;

	logic acc, end_col, end_row, out_free, load_out;
	logic [AW-1:0] first_raddr;
	logic [7:0] prev_rdata, first_rdata;
	logic prev_we, first_we;

	logic [3:0] cand_v, pend, rest;
	logic [RW-1:0] cand_row [4];
	logic [AW-1:0] cand_col [4];
	logic [7:0] cand_hc [4], cand_hl [4], cand_hu [4];
	logic [1:0] sel;
	logic r_last, c_last, r_ge1, c_ge1, r_is1, c_is1;

	nrm_req_t nrm_req;
	nrm_rsp_t nrm_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			row_count_q  <= ROW_COUNT_RST;
			wrap_q       <= 1'b0;
			gain_q       <= SLOPE_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROW_LENGTH: row_length_q <= cfg_wdata[10:0];
				REG_ROW_COUNT:  row_count_q  <= cfg_wdata[10:0];
				REG_WRAP_EDGES: wrap_q       <= cfg_wdata[0];
				REG_SLOPE_GAIN: gain_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp dimensions to [2, max]
	always_comb begin
		if (32'(row_length_q) < 32'd2) begin
			w_m1 = AW'(1);
		end else if (32'(row_length_q) > MAX_WIDTH) begin
			w_m1 = AW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = AW'(32'(row_length_q) - 32'd1);
		end
		if (32'(row_count_q) < 32'd2) begin
			h_m1 = RW'(1);
		end else if (32'(row_count_q) > MAX_HEIGHT) begin
			h_m1 = RW'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = RW'(32'(row_count_q) - 32'd1);
		end
	end

	assign acc      = s_tvalid && s_tready;
	assign end_col  = col_q >= w_m1;
	assign end_row  = row_q >= h_m1;
	assign out_free = !o_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			left_q    <= '0;
			head_lo_q <= '0;
			head_hi_q <= '0;
		end else if (acc) begin
			left_q <= s_tdata;
			if (col_q == '0) begin
				head_hi_q <= head_lo_q;
				head_lo_q <= s_tdata;
			end
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q     <= s_tdata;
			r_it_q    <= row_q;
			c_it_q    <= col_q;
			left_it_q <= left_q;
			hlo_it_q  <= head_lo_q;
			hhi_it_q  <= head_hi_q;
		end
		unique case (state_q)
			SEQ_RD1: begin
				up_q <= prev_rdata;
				fc_q <= first_rdata;
			end
			SEQ_RD2: fc1_q <= first_rdata;
			SEQ_RD3: f0_q  <= first_rdata;
			SEQ_WR:  fw_q  <= first_rdata;
			default: ;
		endcase
	end

	always_comb begin
		unique case (state_q)
			SEQ_RD0: first_raddr = c_it_q;
			SEQ_RD1: first_raddr = c_it_q - AW'(1);
			SEQ_RD2: first_raddr = '0;
			default: first_raddr = w_m1;
		endcase
	end

	hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev_row (
		.clk    (clk),
		.we     (prev_we),
		.waddr  (c_it_q),
		.wdata  (cur_q),
		.raddr  (c_it_q),
		.rdata_q(prev_rdata)
	);

	hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_first_row (
		.clk    (clk),
		.we     (first_we),
		.waddr  (c_it_q),
		.wdata  (cur_q),
		.raddr  (first_raddr),
		.rdata_q(first_rdata)
	);

	// results this sample releases, in raster order
	assign r_last = r_it_q == h_m1;
	assign c_last = c_it_q == w_m1;
	assign r_ge1  = r_it_q != '0;
	assign c_ge1  = c_it_q != '0;
	assign r_is1  = r_it_q == RW'(1);
	assign c_is1  = c_it_q == AW'(1);

	always_comb begin
		cand_row[0] = '0;     cand_col[0] = '0;
		cand_row[1] = '0;     cand_col[1] = c_it_q;
		cand_row[2] = r_it_q; cand_col[2] = '0;
		cand_row[3] = r_it_q; cand_col[3] = c_it_q;
		cand_hc[3] = cur_q; cand_hl[3] = left_it_q; cand_hu[3] = up_q;
		if (wrap_q) begin
			cand_v = {r_ge1 && c_ge1, c_last && r_ge1, r_last && c_ge1, r_last && c_last};
			cand_hc[0] = f0_q;     cand_hl[0] = fw_q;  cand_hu[0] = hlo_it_q;
			cand_hc[1] = fc_q;     cand_hl[1] = fc1_q; cand_hu[1] = cur_q;
			cand_hc[2] = hlo_it_q; cand_hl[2] = cur_q; cand_hu[2] = hhi_it_q;
		end else begin
			// mirror: every result uses this sample with its left and upper neighbors
			cand_v = {r_ge1 && c_ge1, r_ge1 && c_is1, r_is1 && c_ge1, r_is1 && c_is1};
			for (int i = 0; i < 3; i++) begin
				cand_hc[i] = cur_q;
				cand_hl[i] = left_it_q;
				cand_hu[i] = up_q;
			end
		end
	end

	assign pend = cand_v & ~done_q;

	always_comb begin
		priority if (pend[0]) sel = 2'd0;
		else if (pend[1]) sel = 2'd1;
		else if (pend[2]) sel = 2'd2;
		else sel = 2'd3;
	end

	assign rest = pend & ~(4'b0001 << sel);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: if (acc) state_d = SEQ_RD0;
			SEQ_RD0:  state_d = SEQ_RD1;
			SEQ_RD1:  state_d = SEQ_RD2;
			SEQ_RD2:  state_d = SEQ_RD3;
			SEQ_RD3:  state_d = SEQ_WR;
			SEQ_WR:   state_d = SEQ_PICK;
			SEQ_PICK: state_d = (pend == 4'd0) ? SEQ_IDLE : SEQ_CALC;
			SEQ_CALC: if (nrm_rsp.done) state_d = SEQ_OUT;
			SEQ_OUT:  if (out_free) state_d = SEQ_PICK;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == SEQ_IDLE);
		prev_we       = (state_q == SEQ_WR);
		first_we      = (state_q == SEQ_WR) && (r_it_q == '0);
		load_out      = (state_q == SEQ_OUT) && out_free;
		nrm_req.start = (state_q == SEQ_PICK) && (pend != 4'd0);
		nrm_req.hc    = cand_hc[sel];
		nrm_req.hl    = cand_hl[sel];
		nrm_req.hu    = cand_hu[sel];
		nrm_req.gain  = gain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			done_q    <= '0;
			slot_q    <= '0;
			last_q    <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				done_q <= '0;
			end else if (nrm_req.start) begin
				done_q <= done_q | (4'b0001 << sel);
				slot_q <= sel;
				last_q <= rest == 4'd0;
			end
			if (load_out) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_row_q  <= 10'(cand_row[slot_q]);
			o_col_q  <= 10'(cand_col[slot_q]);
			o_x_q    <= nrm_rsp.nx;
			o_y_q    <= nrm_rsp.ny;
			o_z_q    <= nrm_rsp.nz;
			o_last_q <= last_q;
		end
	end

	hnm_normal u_normal (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (nrm_req),
		.rsp   (nrm_rsp)
	);

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {4'd0, ALPHA_VAL, o_z_q, o_y_q, o_x_q, o_col_q, o_row_q};
	assign m_tlast  = o_last_q;

endmodule

### hdl/hnm_ram.sv
module hnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

### hdl/hnm_normal.sv
module hnm_normal import hnm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  nrm_req_t req,
	output nrm_rsp_t rsp
);

	nrm_state_t state_q, state_d;
	logic [5:0] cnt_q;

	logic [7:0]  hc_q, hl_q, hu_q;
	logic [15:0] gain_q;
	logic signed [24:0] dx_q, dy_q;
	logic [49:0] s_q;
	logic [49:0] rem_q;
	logic [32:0] q_q;
	logic [32:0] sv_q;
	logic [33:0] res_q, bit_q;
	logic signed [42:0] px_q, py_q;
	logic [16:0] vx_q, vy_q;
	logic [7:0]  nx_q, ny_q, nz_q;

	logic signed [8:0]  diff_x, diff_y;
	logic signed [16:0] gain_s;
	logic signed [25:0] prod_x, prod_y;
	logic signed [24:0] sq_op, mul_op;
	logic signed [49:0] sq;
	logic [50:0] rem_sh, rem_sub;
	logic        div_ge;
	logic [33:0] sq_try;
	logic        sqrt_ge;
	logic signed [17:0] r_s;
	logic signed [42:0] pr;
	logic signed [49:0] px_w, py_w, mx, my, shx, shy;
	logic [23:0] zr;

	function automatic logic [7:0] div255(input logic [16:0] v);
		logic [25:0] q0w;
		logic [8:0]  q0;
		logic [17:0] rm;
		logic [8:0]  qf;
		q0w = 26'(v) * 26'd257;
		q0  = q0w[24:16];
		rm  = 18'(v) - 18'(q0) * 18'd255;
		qf  = (rm >= 18'd255) ? q0 + 9'd1 : q0;
		return qf[7:0];
	endfunction

	assign diff_x = $signed({1'b0, hl_q}) - $signed({1'b0, hc_q});
	assign diff_y = $signed({1'b0, hu_q}) - $signed({1'b0, hc_q});
	assign gain_s = $signed({1'b0, gain_q});
	assign prod_x = diff_x * gain_s;
	assign prod_y = diff_y * gain_s;

	assign sq_op = (state_q == NRM_SQX) ? dx_q : dy_q;
	assign sq    = sq_op * sq_op;

	assign rem_sh  = {rem_q, 1'b0};
	assign div_ge  = rem_sh >= {1'b0, s_q};
	assign rem_sub = rem_sh - {1'b0, s_q};

	assign sq_try  = res_q + bit_q;
	assign sqrt_ge = {1'b0, sv_q} >= sq_try;

	assign mul_op = (state_q == NRM_MULX) ? dx_q : dy_q;
	assign r_s    = $signed({1'b0, res_q[16:0]});
	assign pr     = mul_op * r_s;

	// 127*p as a shift and subtract, then floor by 2^24
	assign px_w = px_q;
	assign py_w = py_q;
	assign mx   = (px_w <<< 7) - px_w;
	assign my   = (py_w <<< 7) - py_w;
	assign shx  = (mx >>> 24) + LIFT;
	assign shy  = (my >>> 24) + LIFT;
	assign zr   = 24'(res_q[16:0]) * 24'd127;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			NRM_IDLE:  if (req.start) state_d = NRM_DIFF;
			NRM_DIFF:  state_d = NRM_SQX;
			NRM_SQX:   state_d = NRM_SQY;
			NRM_SQY:   state_d = NRM_DIV;
			NRM_DIV:   if (cnt_q == 6'd0) state_d = NRM_SQRT;
			NRM_SQRT:  if (cnt_q == 6'd0) state_d = NRM_MULX;
			NRM_MULX:  state_d = NRM_MULY;
			NRM_MULY:  state_d = NRM_SCALE;
			NRM_SCALE: state_d = NRM_FIX;
			NRM_FIX:   state_d = NRM_DONE;
			NRM_DONE:  state_d = NRM_IDLE;
			default:   state_d = NRM_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == NRM_DONE);
		rsp.nx   = nx_q;
		rsp.ny   = ny_q;
		rsp.nz   = nz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NRM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == NRM_SQY) begin
				cnt_q <= 6'd32;
			end else if (state_q == NRM_DIV) begin
				cnt_q <= (cnt_q == 6'd0) ? 6'd16 : cnt_q - 6'd1;
			end else if (state_q == NRM_SQRT) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			NRM_IDLE: begin
				if (req.start) begin
					hc_q   <= req.hc;
					hl_q   <= req.hl;
					hu_q   <= req.hu;
					gain_q <= req.gain;
				end
			end
			NRM_DIFF: begin
				dx_q <= prod_x[24:0];
				dy_q <= prod_y[24:0];
			end
			NRM_SQX: s_q <= BASE_SQ + $unsigned(sq);
			NRM_SQY: begin
				s_q   <= s_q + $unsigned(sq);
				rem_q <= DIV_SEED;
				q_q   <= '0;
			end
			NRM_DIV: begin
				// one quotient bit per cycle
				rem_q <= div_ge ? rem_sub[49:0] : rem_sh[49:0];
				q_q   <= {q_q[31:0], div_ge};
				if (cnt_q == 6'd0) begin
					sv_q  <= {q_q[31:0], div_ge};
					res_q <= '0;
					bit_q <= 34'h1_0000_0000;
				end
			end
			NRM_SQRT: begin
				if (sqrt_ge) begin
					sv_q  <= 33'({1'b0, sv_q} - sq_try);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			NRM_MULX: px_q <= pr;
			NRM_MULY: py_q <= pr;
			NRM_SCALE: begin
				vx_q <= shx[16:0];
				vy_q <= shy[16:0];
				nz_q <= 8'd128 + zr[23:16];
			end
			NRM_FIX: begin
				nx_q <= div255(vx_q);
				ny_q <= div255(vy_q);
			end
			NRM_DONE: ;
			default: ;
		endcase
	end

endmodule

### hdl/hnm_checker.sv
`include "height_to_normal_map_defines.svh"

module hnm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	`HNM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")
	`HNM_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	`HNM_ASSERT_NOW(a_alpha, m_tvalid, m_tdata[51:44] == 8'hFF, "alpha not opaque")
	`HNM_ASSERT_NOW(a_pad, m_tvalid, m_tdata[55:52] == 4'd0, "pad bits not zero")
	`HNM_ASSERT_NOW(a_z_up, m_tvalid, m_tdata[43], "z component below half scale")

endmodule

bind height_to_normal_map hnm_checker u_hnm_checker (.*);

### tb/sv/height_to_normal_map_test.sv
`timescale 1ns / 100ps

module height_to_normal_map_test;
	import hnm_pkg::*;

	localparam int WIDTH_CAP  = 1024;
	localparam int HEIGHT_CAP = 1024;
	localparam int SETTLE     = 300;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [9:0] row;
		logic [9:0] col;
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] nz;
		logic       last;
	} normal_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = REG_ROW_LENGTH;
	logic [15:0]          cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;
	logic                 m_tlast;

	// configuration as the block sees it
	logic [10:0] cur_row_length = ROW_LENGTH_RST;
	logic [10:0] cur_row_count  = ROW_COUNT_RST;
	logic        cur_wrap = 1'b0;
	logic [15:0] cur_gain = SLOPE_GAIN_RST;

	// image state mirrored from the stream
	logic [7:0]  prev_row[WIDTH_CAP];
	logic [7:0]  first_row[WIDTH_CAP];
	logic [15:0] row_heads = '0;
	logic [7:0]  left_height = '0;
	int unsigned row_pos = 0;
	int unsigned col_pos = 0;

	normal_t pending_normals[$];
	bit      steady = 1'b0;
	bit      failed = 1'b0;
	int      stall_cycles = 0;
	int      heights_sent = 0;
	int      normals_seen = 0;
	int      frames_done = 0;

	height_to_normal_map dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bit_mask;
		res = 0;
		bit_mask = 64'd1 << 62;
		while (bit_mask > v)
			bit_mask >>= 2;
		while (bit_mask != 0) begin
			if (v >= res + bit_mask) begin
				v -= res + bit_mask;
				res = (res >> 1) + bit_mask;
			end else begin
				res >>= 1;
			end
			bit_mask >>= 2;
		end
		return res;
	endfunction

	// 128 + floor(127*d*r / (65280*65536)), floor toward minus infinity
	function automatic logic [7:0] tilt_component(longint d, longint r);
		longint den, prod, t;
		den = 64'sd65280 * 64'sd65536;
		prod = 127 * d * r;
		if (prod >= 0)
			t = prod / den;
		else
			t = -((-prod + den - 1) / den);
		return 8'(128 + t);
	endfunction

	function automatic normal_t surface_normal(int unsigned row, int unsigned col,
			logic [7:0] hc, logic [7:0] hl, logic [7:0] hu);
		normal_t n;
		longint dx, dy;
		longint unsigned mag_sq, unit, inv_mag;
		dx = (longint'(hl) - longint'(hc)) * longint'(cur_gain);
		dy = (longint'(hu) - longint'(hc)) * longint'(cur_gain);
		mag_sq = longint'(dx * dx) + longint'(dy * dy) + 64'd65280 * 64'd65280;
		unit = 64'd65280 * 64'd65536;
		inv_mag = root_floor((unit * unit) / mag_sq);
		n.row = row[9:0];
		n.col = col[9:0];
		n.nx = tilt_component(dx, longint'(inv_mag));
		n.ny = tilt_component(dy, longint'(inv_mag));
		n.nz = 8'(128 + ((127 * inv_mag) >> 16));
		n.last = 1'b0;
		return n;
	endfunction

	function automatic int unsigned clamp_size(logic [10:0] v, int unsigned cap);
		if (v < 2)
			return 2;
		if (v > cap)
			return cap;
		return v;
	endfunction

	// advance the image state by one height and queue the normals it releases
	function automatic void take_height(logic [7:0] cur);
		normal_t found[$];
		int unsigned w, h, r, c;
		logic [7:0] up, head_lo, head_hi;
		w = clamp_size(cur_row_length, WIDTH_CAP);
		h = clamp_size(cur_row_count, HEIGHT_CAP);
		r = row_pos;
		c = col_pos;
		up = prev_row[c];
		head_lo = row_heads[7:0];
		head_hi = row_heads[15:8];
		if (cur_wrap) begin
			if (r == h - 1 && c == w - 1)
				found.push_back(surface_normal(0, 0, first_row[0], first_row[w - 1], head_lo));
			if (r == h - 1 && c >= 1)
				found.push_back(surface_normal(0, c, first_row[c], first_row[c - 1], cur));
			if (c == w - 1 && r >= 1)
				found.push_back(surface_normal(r, 0, head_lo, cur, head_hi));
			if (r >= 1 && c >= 1)
				found.push_back(surface_normal(r, c, cur, left_height, up));
		end else begin
			if (r == 1 && c == 1)
				found.push_back(surface_normal(0, 0, cur, left_height, up));
			if (r == 1 && c >= 1)
				found.push_back(surface_normal(0, c, cur, left_height, up));
			if (r >= 1 && c == 1)
				found.push_back(surface_normal(r, 0, cur, left_height, up));
			if (r >= 1 && c >= 1)
				found.push_back(surface_normal(r, c, cur, left_height, up));
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			pending_normals.push_back(found[i]);

		prev_row[c] = cur;
		if (r == 0)
			first_row[c] = cur;
		if (c == 0)
			row_heads = {head_lo, cur};
		left_height = cur;
		if (c >= w - 1) begin
			col_pos = 0;
			row_pos = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= 28);

	always @(posedge clk) begin
		normal_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				take_height(s_tdata);
				heights_sent++;
			end
			if (m_tvalid && m_tready) begin
				normals_seen++;
				if (pending_normals.size() == 0) begin
					$error("unexpected normal row %0d column %0d", m_tdata[9:0], m_tdata[19:10]);
					failed = 1'b1;
				end else begin
					want = pending_normals.pop_front();
					if (m_tdata[9:0] !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, m_tdata[9:0]);
						failed = 1'b1;
					end
					if (m_tdata[19:10] !== want.col) begin
						$error("out_column: expected %0d, got %0d", want.col, m_tdata[19:10]);
						failed = 1'b1;
					end
					if (m_tdata[27:20] !== want.nx) begin
						$error("normal_x: expected %0d, got %0d", want.nx, m_tdata[27:20]);
						failed = 1'b1;
					end
					if (m_tdata[35:28] !== want.ny) begin
						$error("normal_y: expected %0d, got %0d", want.ny, m_tdata[35:28]);
						failed = 1'b1;
					end
					if (m_tdata[43:36] !== want.nz) begin
						$error("normal_z: expected %0d, got %0d", want.nz, m_tdata[43:36]);
						failed = 1'b1;
					end
					if (m_tdata[51:44] !== ALPHA_VAL) begin
						$error("normal_alpha: expected %0d, got %0d", ALPHA_VAL, m_tdata[51:44]);
						failed = 1'b1;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
						failed = 1'b1;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("** height_to_normal_map: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_ROW_LENGTH: cur_row_length = value[10:0];
			REG_ROW_COUNT:  cur_row_count = value[10:0];
			REG_WRAP_EDGES: cur_wrap = value[0];
			default:        cur_gain = value;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// s_tvalid stays high from one item to the next unless an idle cycle falls between
	task automatic send_height(logic [7:0] h);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= h;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		// heights without a normal may still be in flight
		repeat (SETTLE) @(posedge clk);
	endtask

	// pattern: 0 random, 1 full-swing checkerboard, 2 ramp
	task automatic run_frame(logic [10:0] len, logic [10:0] cnt, logic wrap,
			logic [15:0] gain, int pattern);
		int unsigned w, h;
		logic [7:0] v;
		write_reg(REG_ROW_LENGTH, 16'(len));
		write_reg(REG_ROW_COUNT, 16'(cnt));
		write_reg(REG_WRAP_EDGES, 16'(wrap));
		write_reg(REG_SLOPE_GAIN, gain);
		w = clamp_size(len, WIDTH_CAP);
		h = clamp_size(cnt, HEIGHT_CAP);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				case (pattern)
					1:       v = ((r + c) % 2) ? 8'hFF : 8'h00;
					2:       v = 8'(r * 37 + c * 11);
					default: v = 8'($urandom_range(255));
				endcase
				send_height(v);
			end
		drain();
		frames_done++;
	endtask

	task automatic test_edges_directed;
		run_frame(11'd3, 11'd3, 1'b0, 16'hFFFF, 1);
		run_frame(11'd3, 11'd3, 1'b1, 16'hFFFF, 1);
		run_frame(11'd2, 11'd2, 1'b1, 16'h0000, 2);
		run_frame(11'd1, 11'd0, 1'b0, 16'd256, 1);
	endtask

	// both sides always ready for a whole frame
	task automatic test_steady_run;
		steady = 1'b1;
		run_frame(11'd8, 11'd6, 1'($urandom_range(1)), 16'($urandom), 0);
		steady = 1'b0;
	endtask

	task automatic test_random_frames;
		logic [15:0] gain;
		int start;
		start = heights_sent;
		while (heights_sent - start < 240) begin
			case ($urandom_range(5))
				0:       gain = 16'hFFFF;
				1:       gain = 16'd0;
				2:       gain = 16'($urandom_range(512));
				default: gain = 16'($urandom);
			endcase
			steady = ($urandom_range(7) == 0);
			run_frame(11'($urandom_range(12)), 11'($urandom_range(8)),
				1'($urandom_range(1)), gain, ($urandom_range(5) == 0) ? 2 : 0);
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_edges_directed();
		test_steady_run();
		test_random_frames();
		$display("covered %0d frames, %0d heights, %0d normals", frames_done,
			heights_sent, normals_seen);
		$display("mirror and wrap edges, gain extremes, sizes below 2 raised to 2, a frame with no idling");
		if (!failed && pending_normals.size() == 0)
			$display("** height_to_normal_map: PASSED **");
		else
			$display("** height_to_normal_map: FAILED **");
		$finish;
	end

endmodule

### height_to_normal_map.f
+incdir+hdl
hdl/hnm_pkg.sv
hdl/hnm_ram.sv
hdl/hnm_normal.sv
hdl/height_to_normal_map.sv
hdl/hnm_checker.sv
tb/sv/height_to_normal_map_test.sv
